@@ design/autoscaled_scatter_dot_plotter_macros.svh @@
// assertion helpers used by the plotter sequencer (asdp_ctrl)
// each macro expects aclk and aresetn in the enclosing scope
`ifndef AUTOSCALED_SCATTER_DOT_PLOTTER_MACROS_SVH
`define AUTOSCALED_SCATTER_DOT_PLOTTER_MACROS_SVH

// same-cycle implication
`define ASDP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASDP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/asdp_pkg.sv @@
`default_nettype none

package asdp_pkg;

    // pixel coordinate arithmetic wraps at this many bits
    localparam int PIXEL_COORD_BITS = 10;

    localparam int VAL_W      = 32;
    localparam int RADIUS_W   = 2;
    localparam int PLOT_W     = 10;
    localparam int ORIGIN_W   = 9;
    localparam int OUT_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int PROD_W     = VAL_W + PLOT_W;
    localparam int DIV_STEPS  = PLOT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int OFS_W      = RADIUS_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DOT_RADIUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLOT_SIZE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_OFFSET = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 2'd3;
    localparam logic [PLOT_W-1:0]   PLOT_RST   = 10'd560;
    localparam logic [ORIGIN_W-1:0] ORIGIN_RST = 9'd120;

    localparam logic MODE_RANGE = 1'b0;
    localparam logic MODE_DRAW  = 1'b1;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef struct packed {
        logic load_range;
        logic load_draw;
        logic clamp;
        logic diff;
        logic mul;
        logic div_step;
        logic store;
        logic emit_init;
        logic emit_step;
        logic axis;
    } asdp_cmd_t;

    typedef struct packed {
        logic last_pix;
    } asdp_stat_t;

endpackage

`default_nettype wire

@@ design/autoscaled_scatter_dot_plotter.sv @@
// range word: taken with no output, ready again the next cycle
// draw word: each axis clamps, subtracts, multiplies, divides to a 10-bit quotient, stores,
//   x then y; the pixel words start once the y result is stored
// then (2*dot_radius+1)^2 pixel words, one per cycle while m_ready is high, so a draw word
//   holds off the input until its last pixel word is taken
// aresetn synchronous active low: range zeroed, radius 3, span 560, origin 120, idle
`default_nettype none

module autoscaled_scatter_dot_plotter (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [asdp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [asdp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // point input
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_mode,
    input  wire logic                              s_first,
    input  wire logic signed [asdp_pkg::VAL_W-1:0] s_x_value,
    input  wire logic signed [asdp_pkg::VAL_W-1:0] s_y_value,
    // pixel output
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [asdp_pkg::OUT_W-1:0]             m_pixel_col,
    output logic [asdp_pkg::OUT_W-1:0]             m_pixel_row,
    output logic                                   m_last_pixel
);
    import asdp_pkg::*;

    // command and status between sequencer and datapath
    asdp_cmd_t  cmd;
    asdp_stat_t stat;

    // sequencer: accepts words, steps the scaling unit, paces the dot scan
    asdp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: config registers, range tracking, scale unit, pixel offsets
    asdp_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_first      (s_first),
        .s_x_value    (s_x_value),
        .s_y_value    (s_y_value),
        .cmd          (cmd),
        .stat         (stat),
        .m_pixel_col  (m_pixel_col),
        .m_pixel_row  (m_pixel_row),
        .m_last_pixel (m_last_pixel)
    );

endmodule

`default_nettype wire

@@ design/asdp_ctrl.sv @@
`default_nettype none
`include "autoscaled_scatter_dot_plotter_macros.svh"

module asdp_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_mode,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire asdp_pkg::asdp_stat_t stat,
    output asdp_pkg::asdp_cmd_t     cmd
);
    import asdp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_DIFF,
        ST_MUL,
        ST_DIV,
        ST_STORE,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic                 axis_reg, axis_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic in_acc;
    logic out_acc;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);
    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_mode == MODE_DRAW) begin
                        cmd.load_draw = 1'b1;
                        axis_next     = AXIS_X;
                        state_next    = ST_CLAMP;
                    end else begin
                        cmd.load_range = 1'b1;
                    end
                end
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                if (axis_reg == AXIS_X) begin
                    axis_next  = AXIS_Y;
                    state_next = ST_CLAMP;
                end else begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_acc) begin
                    cmd.emit_step = 1'b1;
                    if (stat.last_pix) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= AXIS_X;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
        end
    end

    `ASDP_ASSERT_NOW(a_no_accept_while_emit, m_valid, !s_ready, "input taken during emission")
    `ASDP_ASSERT_NEXT(a_draw_starts_scale, in_acc && (s_mode == MODE_DRAW),
        state_reg == ST_CLAMP && axis_reg == AXIS_X, "draw word did not start scaling")
    `ASDP_ASSERT_NEXT(a_range_stays_idle, in_acc && (s_mode == MODE_RANGE), s_ready,
        "range word left idle")
    `ASDP_ASSERT_NEXT(a_last_returns_idle, out_acc && stat.last_pix, s_ready && !m_valid,
        "no return to idle after last pixel")

endmodule

`default_nettype wire

@@ design/asdp_dpath.sv @@
`default_nettype none

module asdp_dpath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [asdp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [asdp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_first,
    input  wire logic signed [asdp_pkg::VAL_W-1:0] s_x_value,
    input  wire logic signed [asdp_pkg::VAL_W-1:0] s_y_value,
    input  wire asdp_pkg::asdp_cmd_t               cmd,
    output asdp_pkg::asdp_stat_t                   stat,
    output logic [asdp_pkg::OUT_W-1:0]             m_pixel_col,
    output logic [asdp_pkg::OUT_W-1:0]             m_pixel_row,
    output logic                                   m_last_pixel
);
    import asdp_pkg::*;

    // configuration
    logic [RADIUS_W-1:0] radius_reg;
    logic [PLOT_W-1:0]   plot_reg;
    logic [ORIGIN_W-1:0] origin_reg;

    // tracked range
    logic signed [VAL_W-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;

    // draw point and scaling pipeline
    logic signed [VAL_W-1:0] x_raw_reg, y_raw_reg;
    logic [VAL_W-1:0]        val_reg;
    logic [VAL_W-1:0]        span_reg;
    logic                    degen_reg;
    logic [PROD_W-1:0]       rem_reg;
    logic [PROD_W-1:0]       dvs_reg;
    logic [PLOT_W-1:0]       q_reg;
    logic [PLOT_W-1:0]       xs_reg, ys_reg;

    // dot scan offsets
    logic signed [OFS_W-1:0] j_reg, k_reg;

    logic signed [VAL_W-1:0] v_sel, lo_sel, hi_sel;
    logic [PLOT_W-1:0]       scaled;
    logic signed [OFS_W-1:0] r_s;
    logic                    k_end, j_end;
    logic [PIXEL_COORD_BITS-1:0] col_sum, row_sum;

    always_comb begin
        if (cmd.axis == AXIS_Y) begin
            v_sel  = y_raw_reg;
            lo_sel = min_y_reg;
            hi_sel = max_y_reg;
        end else begin
            v_sel  = x_raw_reg;
            lo_sel = min_x_reg;
            hi_sel = max_x_reg;
        end
    end

    assign scaled = degen_reg ? (plot_reg >> 1) : q_reg;
    assign r_s    = $signed({1'b0, radius_reg});
    assign k_end  = (k_reg == r_s);
    assign j_end  = (j_reg == r_s);

    assign stat.last_pix = k_end && j_end;

    assign col_sum = PIXEL_COORD_BITS'(origin_reg) + PIXEL_COORD_BITS'(xs_reg)
                   + PIXEL_COORD_BITS'(k_reg);
    assign row_sum = PIXEL_COORD_BITS'(origin_reg) + PIXEL_COORD_BITS'(ys_reg)
                   + PIXEL_COORD_BITS'(j_reg);

    assign m_pixel_col  = OUT_W'(col_sum);
    assign m_pixel_row  = OUT_W'(row_sum);
    assign m_last_pixel = stat.last_pix;

    // config and range state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RST;
            plot_reg   <= PLOT_RST;
            origin_reg <= ORIGIN_RST;
            min_x_reg  <= '0;
            max_x_reg  <= '0;
            min_y_reg  <= '0;
            max_y_reg  <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DOT_RADIUS:    radius_reg <= cfg_wdata[RADIUS_W-1:0];
                    CFG_PLOT_SIZE:     plot_reg   <= cfg_wdata[PLOT_W-1:0];
                    CFG_ORIGIN_OFFSET: origin_reg <= cfg_wdata[ORIGIN_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load_range) begin
                if (s_first) begin
                    min_x_reg <= s_x_value;
                    max_x_reg <= s_x_value;
                    min_y_reg <= s_y_value;
                    max_y_reg <= s_y_value;
                end else begin
                    if (s_x_value < min_x_reg) min_x_reg <= s_x_value;
                    if (s_x_value > max_x_reg) max_x_reg <= s_x_value;
                    if (s_y_value < min_y_reg) min_y_reg <= s_y_value;
                    if (s_y_value > max_y_reg) max_y_reg <= s_y_value;
                end
            end
        end
    end

    // payload path, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.load_draw) begin
            x_raw_reg <= s_x_value;
            y_raw_reg <= s_y_value;
        end
        if (cmd.clamp) begin
            if (v_sel < lo_sel) begin
                val_reg <= lo_sel;
            end else if (v_sel > hi_sel) begin
                val_reg <= hi_sel;
            end else begin
                val_reg <= v_sel;
            end
            span_reg  <= hi_sel - lo_sel;
            degen_reg <= (lo_sel >= hi_sel);
        end
        if (cmd.diff) begin
            val_reg <= val_reg - lo_sel;
        end
        if (cmd.mul) begin
            rem_reg <= PROD_W'(val_reg) * PROD_W'(plot_reg);
            dvs_reg <= PROD_W'(span_reg) << (DIV_STEPS - 1);
            q_reg   <= '0;
        end
        // restoring divide, one quotient bit per cycle
        if (cmd.div_step) begin
            if (rem_reg >= dvs_reg) begin
                rem_reg <= rem_reg - dvs_reg;
                q_reg   <= {q_reg[PLOT_W-2:0], 1'b1};
            end else begin
                q_reg   <= {q_reg[PLOT_W-2:0], 1'b0};
            end
            dvs_reg <= dvs_reg >> 1;
        end
        if (cmd.store) begin
            if (cmd.axis == AXIS_Y) begin
                ys_reg <= scaled;
            end else begin
                xs_reg <= scaled;
            end
        end
        if (cmd.emit_init) begin
            j_reg <= -r_s;
            k_reg <= -r_s;
        end else if (cmd.emit_step) begin
            if (k_end) begin
                k_reg <= -r_s;
                j_reg <= j_reg + OFS_W'(1);
            end else begin
                k_reg <= k_reg + OFS_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import asdp_pkg::*;

    // one expected dot pixel word
    typedef struct packed {
        logic [OUT_W-1:0] col;
        logic [OUT_W-1:0] row;
        logic             last_pixel;
    } pixel_word_t;

    // how a stimulus frame spreads its range samples
    typedef enum int {
        SPREAD_SMALL,
        SPREAD_FULL,
        SPREAD_EXTREME,
        SPREAD_FLAT
    } spread_t;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam int RANDOM_WORDS = 335;
    localparam int CALM_AFTER   = 280;

    // predicts the pixel words of every accepted point word and checks the output
    class pixel_scoreboard;
        logic [RADIUS_W-1:0]       radius;
        logic [PLOT_W-1:0]         plot;
        logic [ORIGIN_W-1:0]       origin;
        logic signed [VAL_W-1:0]   min_x, max_x, min_y, max_y;
        pixel_word_t               pending_pixels[$];
        int                        fault_count;

        function new();
            radius      = RADIUS_RST;
            plot        = PLOT_RST;
            origin      = ORIGIN_RST;
            min_x       = '0;
            max_x       = '0;
            min_y       = '0;
            max_y       = '0;
            fault_count = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DOT_RADIUS:    radius = data[RADIUS_W-1:0];
                CFG_PLOT_SIZE:     plot   = data[PLOT_W-1:0];
                CFG_ORIGIN_OFFSET: origin = data[ORIGIN_W-1:0];
                default: ;
            endcase
        endfunction

        // (v - lo) * plot / (hi - lo) with v clamped, or plot / 2 on a flat range
        function int scale_axis(logic signed [VAL_W-1:0] v, logic signed [VAL_W-1:0] lo,
                                logic signed [VAL_W-1:0] hi);
            longint sv, slo, shi;
            sv  = longint'(v);
            slo = longint'(lo);
            shi = longint'(hi);
            if (slo >= shi)
                return int'(plot) / 2;
            if (sv < slo) sv = slo;
            if (sv > shi) sv = shi;
            return int'(((sv - slo) * longint'(plot)) / (shi - slo));
        endfunction

        function logic [OUT_W-1:0] wrap_coord(int scaled, int delta);
            int c;
            c = int'(origin) + scaled + delta;
            return c[PIXEL_COORD_BITS-1:0];
        endfunction

        function void note_point(logic mode, logic first, logic signed [VAL_W-1:0] x,
                                 logic signed [VAL_W-1:0] y);
            int xs, ys, r;
            pixel_word_t w;
            if (mode == MODE_RANGE) begin
                if (first) begin
                    min_x = x; max_x = x;
                    min_y = y; max_y = y;
                end else begin
                    if (x < min_x) min_x = x;
                    if (x > max_x) max_x = x;
                    if (y < min_y) min_y = y;
                    if (y > max_y) max_y = y;
                end
            end else begin
                xs = scale_axis(x, min_x, max_x);
                ys = scale_axis(y, min_y, max_y);
                r  = int'(radius);
                for (int j = -r; j <= r; j++) begin
                    for (int k = -r; k <= r; k++) begin
                        w.col        = wrap_coord(xs, k);
                        w.row        = wrap_coord(ys, j);
                        w.last_pixel = (j == r && k == r);
                        pending_pixels.push_back(w);
                    end
                end
            end
        endfunction

        function void check_pixel(logic [OUT_W-1:0] col, logic [OUT_W-1:0] row,
                                  logic last_pixel);
            pixel_word_t w;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel word: expected none, actual col %0d row %0d last %0d",
                         $time, col, row, last_pixel);
                fault_count++;
                return;
            end
            w = pending_pixels.pop_front();
            if (col !== w.col) begin
                $display("%0t: pixel_col mismatch: expected %0d, actual %0d", $time, w.col, col);
                fault_count++;
            end
            if (row !== w.row) begin
                $display("%0t: pixel_row mismatch: expected %0d, actual %0d", $time, w.row, row);
                fault_count++;
            end
            if (last_pixel !== w.last_pixel) begin
                $display("%0t: last_pixel mismatch: expected %0d, actual %0d",
                         $time, w.last_pixel, last_pixel);
                fault_count++;
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    // clock, reset and every block input start at a known value
    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index   = CFG_DOT_RADIUS;
    logic [CFG_DATA_W-1:0]    cfg_wdata   = '0;
    logic                     s_valid     = 1'b0;
    logic                     s_ready;
    logic                     s_mode      = MODE_RANGE;
    logic                     s_first     = 1'b0;
    logic signed [VAL_W-1:0]  s_x_value   = '0;
    logic signed [VAL_W-1:0]  s_y_value   = '0;
    logic                     m_valid;
    logic                     m_ready     = 1'b0;
    logic [OUT_W-1:0]         m_pixel_col;
    logic [OUT_W-1:0]         m_pixel_row;
    logic                     m_last_pixel;

    pixel_scoreboard sb;
    bit              calm = 1'b0;   // no idling on either side in the last stretch
    int              words_sent = 0;
    int              stall_left = 0;

    autoscaled_scatter_dot_plotter uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_first      (s_first),
        .s_x_value    (s_x_value),
        .s_y_value    (s_y_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_col  (m_pixel_col),
        .m_pixel_row  (m_pixel_row),
        .m_last_pixel (m_last_pixel)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #6_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // result side: check each accepted pixel word, then pick next cycle's ready
    // stalls come in bursts whose length is drawn at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_pixel(m_pixel_col, m_pixel_row, m_last_pixel);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 8);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // offer one point word, now and then with a random idle burst ahead of it, and wait for the handshake
    // valid is only lowered when a gap follows, so it never toggles within one step
    task automatic send_point(logic mode, logic first, logic signed [VAL_W-1:0] x,
                              logic signed [VAL_W-1:0] y);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_first   <= first;
        s_x_value <= x;
        s_y_value <= y;
        do @(posedge aclk); while (!s_ready);
        sb.note_point(mode, first, x, y);
        words_sent++;
    endtask

    // sender holds off until every expected pixel word is out, then pads with idle clocks
    // so that a range word still in flight has settled too
    task automatic wait_for_pixels();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // back-to-back writes of all three registers, only while the block is idle
    task automatic configure(logic [CFG_DATA_W-1:0] radius_data,
                             logic [CFG_DATA_W-1:0] plot_data,
                             logic [CFG_DATA_W-1:0] origin_data);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DOT_RADIUS;
        cfg_wdata <= radius_data;
        @(posedge aclk);
        sb.set_reg(CFG_DOT_RADIUS, radius_data);
        cfg_index <= CFG_PLOT_SIZE;
        cfg_wdata <= plot_data;
        @(posedge aclk);
        sb.set_reg(CFG_PLOT_SIZE, plot_data);
        cfg_index <= CFG_ORIGIN_OFFSET;
        cfg_wdata <= origin_data;
        @(posedge aclk);
        sb.set_reg(CFG_ORIGIN_OFFSET, origin_data);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value(spread_t spread);
        case (spread)
            // about +-1000.0 in q16.16
            SPREAD_SMALL: return int'($urandom_range(0, 131072000)) - 65536000;
            SPREAD_FULL:  return $urandom;
            default: begin
                case ($urandom_range(0, 4))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return 32'sd0;
                    3:       return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_between(longint lo, longint hi);
        return VAL_W'(lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
    endfunction

    // random register setting, extremes weighted in; radius data carries junk upper bits
    task automatic random_configure();
        logic [CFG_DATA_W-1:0] rd, pd, od;
        rd = {8'($urandom_range(0, 255)), 2'($urandom_range(0, 3))};
        case ($urandom_range(0, 7))
            0:       pd = 10'd1;
            1:       pd = 10'd1023;
            2:       pd = 10'd0;
            default: pd = 10'($urandom_range(1, 1023));
        endcase
        case ($urandom_range(0, 5))
            0:       od = 10'd0;
            1:       od = 10'd511;
            default: od = {1'($urandom_range(0, 1)), 9'($urandom_range(0, 511))};
        endcase
        configure(rd, pd, od);
    endtask

    // one well-formed frame: a range pass, then draws mostly inside the tracked range
    task automatic run_frame();
        spread_t spread;
        int n_range, n_draw, sel;
        logic first;
        logic signed [VAL_W-1:0] x, y, flat_x, flat_y;
        longint lo_x, hi_x, lo_y, hi_y;
        sel = $urandom_range(0, 9);
        spread = (sel < 6) ? SPREAD_SMALL : (sel < 8) ? SPREAD_FULL :
                 (sel == 8) ? SPREAD_EXTREME : SPREAD_FLAT;
        flat_x  = pick_value(SPREAD_FULL);
        flat_y  = pick_value(SPREAD_FULL);
        n_range = $urandom_range(1, 5);
        n_draw  = $urandom_range(1, 6);
        lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0;
        for (int i = 0; i < n_range; i++) begin
            if (spread == SPREAD_FLAT) begin
                x = flat_x;
                y = flat_y;
            end else begin
                x = pick_value(spread);
                y = pick_value(spread);
            end
            // mostly a clean restart, now and then a pass that keeps the old range
            first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
            if (i == 0 || first) begin
                lo_x = longint'(x); hi_x = longint'(x);
                lo_y = longint'(y); hi_y = longint'(y);
            end else begin
                if (x < lo_x) lo_x = longint'(x);
                if (x > hi_x) hi_x = longint'(x);
                if (y < lo_y) lo_y = longint'(y);
                if (y > hi_y) hi_y = longint'(y);
            end
            send_point(MODE_RANGE, first, x, y);
        end
        for (int i = 0; i < n_draw; i++) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                x = pick_between(lo_x, hi_x);
                y = pick_between(lo_y, hi_y);
            end else if (sel < 9) begin
                // may fall outside the range and get clamped
                x = pick_value((spread == SPREAD_FLAT) ? SPREAD_SMALL : spread);
                y = pick_value((spread == SPREAD_FLAT) ? SPREAD_SMALL : spread);
            end else begin
                x = pick_value(SPREAD_EXTREME);
                y = pick_value(SPREAD_EXTREME);
            end
            // first flag on a draw word is ignored by the block
            send_point(MODE_DRAW, 1'($urandom_range(0, 1)), x, y);
        end
    endtask

    // noise: mode and first flags at random, values anywhere
    task automatic run_noise();
        int n;
        n = $urandom_range(3, 6);
        for (int i = 0; i < n; i++)
            send_point(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       pick_value(($urandom_range(0, 1) == 0) ? SPREAD_FULL : SPREAD_EXTREME),
                       pick_value(($urandom_range(0, 1) == 0) ? SPREAD_FULL : SPREAD_SMALL));
    endtask

    initial begin
        int base;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, reset register values first
        // draw before any range word: both axes land on half the plot span
        send_point(MODE_DRAW, 1'b0, 32'sh1234_5678, -32'sd5);
        // widest possible range, then draws at both ends and in the middle
        send_point(MODE_RANGE, 1'b1, VAL_MIN, VAL_MAX);
        send_point(MODE_RANGE, 1'b0, VAL_MAX, VAL_MIN);
        send_point(MODE_DRAW, 1'b0, VAL_MAX, VAL_MIN);
        send_point(MODE_DRAW, 1'b1, 32'sd0, 32'sd0);
        send_point(MODE_DRAW, 1'b0, VAL_MIN, VAL_MAX);
        // restart with a moderate range, a non-restart word that changes nothing
        send_point(MODE_RANGE, 1'b1, -32'sd100 <<< 16, 32'sd300 <<< 16);
        send_point(MODE_RANGE, 1'b0, 32'sd200 <<< 16, -32'sd50 <<< 16);
        send_point(MODE_RANGE, 1'b0, 32'sd0, 32'sd0);
        send_point(MODE_DRAW, 1'b0, 32'sd50 <<< 16, 32'sd125 <<< 16);
        // points outside the range get clamped
        send_point(MODE_DRAW, 1'b0, -32'sd500 <<< 16, 32'sd400 <<< 16);
        send_point(MODE_DRAW, 1'b0, VAL_MAX, VAL_MIN);
        // flat range: min equals max
        send_point(MODE_RANGE, 1'b1, 32'sd7, 32'sd7);
        send_point(MODE_DRAW, 1'b0, 32'sd7, -32'sd9);
        send_point(MODE_DRAW, 1'b0, -32'sd1, 32'sd1);

        // single-pixel dot, zero plot size, zero origin; junk bits above the radius
        wait_for_pixels();
        configure(10'h3fc, 10'd0, 10'd0);
        send_point(MODE_RANGE, 1'b1, -32'sd1000, 32'sd1000);
        send_point(MODE_RANGE, 1'b0, 32'sd1000, -32'sd1000);
        send_point(MODE_DRAW, 1'b0, 32'sd0, 32'sd0);
        send_point(MODE_DRAW, 1'b0, 32'sd1000, -32'sd1000);

        // largest plot and origin: columns wrap past the top of the pixel range
        wait_for_pixels();
        configure(10'd3, 10'd1023, 10'd511);
        send_point(MODE_DRAW, 1'b0, 32'sd1000, -32'sd1000);
        send_point(MODE_DRAW, 1'b0, 32'sd0, 32'sd0);

        // origin zero with a full dot: coordinates below zero wrap
        wait_for_pixels();
        configure(10'd3, 10'd1, 10'd0);
        send_point(MODE_DRAW, 1'b0, -32'sd1000, -32'sd1000);
        send_point(MODE_DRAW, 1'b0, 32'sd1000, 32'sd1000);

        // random part: frames, now and then noise, register changes and full drains
        base = words_sent;
        while (words_sent - base < RANDOM_WORDS) begin
            calm = (words_sent - base >= CALM_AFTER);
            if ($urandom_range(0, 3) == 0) begin
                wait_for_pixels();
                random_configure();
            end else if ($urandom_range(0, 7) == 0) begin
                wait_for_pixels();
            end
            if ($urandom_range(0, 5) == 0)
                run_noise();
            else
                run_frame();
        end

        // drain and let the block settle before the verdict
        wait_for_pixels();
        repeat (40) @(posedge aclk);
        if (sb.fault_count == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/asdp_pkg.sv
design/asdp_ctrl.sv
design/asdp_dpath.sv
design/autoscaled_scatter_dot_plotter.sv
verif/testbench.sv
